FILE: design/fcc_pkg.sv
package fcc_pkg;

    // fixed field widths
    localparam int OP_W   = 3;
    localparam int CLU_W  = 10;
    localparam int LINK_W = 28;
    localparam int STAT_W = 2;
    localparam int CFG_W  = 11;

    // opcodes
    localparam logic [OP_W-1:0] OP_WRITE = 3'd0;
    localparam logic [OP_W-1:0] OP_READ  = 3'd1;
    localparam logic [OP_W-1:0] OP_TRACE = 3'd2;
    localparam logic [OP_W-1:0] OP_FREE  = 3'd3;
    localparam logic [OP_W-1:0] OP_ALLOC = 3'd4;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;
    localparam logic [STAT_W-1:0] ST_TRUNC = 2'd3;

    // link values
    localparam logic [LINK_W-1:0] END_LIMIT = 28'hFFFFFF8;
    localparam logic [LINK_W-1:0] END_MARK  = 28'hFFFFFFF;
    localparam logic [LINK_W-1:0] FREE_VAL  = 28'h0000000;

    localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

    // table write source
    typedef enum logic [1:0] {
        WK_VAL  = 2'd0,
        WK_ZERO = 2'd1,
        WK_END  = 2'd2,
        WK_LINK = 2'd3
    } wr_kind_t;

    // result formats
    typedef enum logic [2:0] {
        R_ERR       = 3'd0,
        R_ALLOC_ERR = 3'd1,
        R_FULL      = 3'd2,
        R_ALLOC_OK  = 3'd3,
        R_WRITE     = 3'd4,
        R_READ      = 3'd5,
        R_TRACE     = 3'd6,
        R_FREE      = 3'd7
    } res_kind_t;

    // controller to datapath
    typedef struct packed {
        logic      load;
        logic      rd_en;
        logic      rd_k;
        logic      wr_en;
        wr_kind_t  wr_kind;
        logic      adv_cur;
        logic      adv_k;
        logic      set_res;
        res_kind_t res_kind;
        logic      emit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            in_range;
        logic            link_prev;
        logic            k_out;
        logic            k_next_out;
        logic            rd_zero;
        logic            free_done;
        logic            pend_last;
        logic            out_free;
    } stat_t;

endpackage

FILE: design/fcc_ram.sv
module fcc_ram #(
    parameter int WIDTH = 28,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/fcc_datapath.sv
module fcc_datapath import fcc_pkg::*; #(
    parameter int ENTRIES = 1024,
    parameter int MAX_RUN = 64
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  cmd_t                      cmd,
    output stat_t                     stat,
    input  logic                      cfg_we,
    input  logic [CFG_W-1:0]          cfg_wdata,
    input  logic [OP_W-1:0]           in_opcode,
    input  logic [CLU_W-1:0]          in_cluster,
    input  logic [LINK_W-1:0]         in_link_value,
    input  logic                      in_link_prev,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [CLU_W+LINK_W+STAT_W-1:0] m_axis_tdata,
    output logic                      m_axis_tlast
);

    localparam int AW      = $clog2(ENTRIES);
    localparam int LIM_W   = $clog2(ENTRIES + 1);
    localparam int CNT_MAX = (ENTRIES > MAX_RUN) ? ENTRIES : MAX_RUN;
    localparam int CNT_W   = $clog2(CNT_MAX + 1);
    localparam int CX_W    = (AW > CLU_W) ? AW : CLU_W;
    localparam int KX_W    = (LIM_W > CLU_W) ? LIM_W : CLU_W;
    localparam int LX_W    = (LIM_W > CFG_W) ? LIM_W : CFG_W;

    logic [CFG_W-1:0]  cfg_reg, cfg_next;
    logic [OP_W-1:0]   op_reg, op_next;
    logic [CLU_W-1:0]  clu_reg, clu_next;
    logic [LINK_W-1:0] val_reg, val_next;
    logic              linkp_reg, linkp_next;
    logic [AW-1:0]     cur_reg, cur_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [LIM_W-1:0]  k_reg, k_next;

    logic [CLU_W-1:0]  pclu_reg, pclu_next;
    logic [LINK_W-1:0] pval_reg, pval_next;
    logic [STAT_W-1:0] pst_reg, pst_next;
    logic              plast_reg, plast_next;

    logic              mvalid_reg, mvalid_next;
    logic [CLU_W-1:0]  mclu_reg, mclu_next;
    logic [LINK_W-1:0] mval_reg, mval_next;
    logic [STAT_W-1:0] mst_reg, mst_next;
    logic              mlast_reg, mlast_next;

    logic [LX_W-1:0]   cfg_x;
    logic [LIM_W-1:0]  lim;
    logic [CX_W-1:0]   clu_x;
    logic [CX_W-1:0]   cur_x;
    logic [KX_W-1:0]   k_x;
    logic [AW-1:0]     clu_idx;
    logic [AW-1:0]     k_idx;
    logic [LINK_W-1:0] rd_data;
    logic              link_ok;
    logic              link_in;
    logic              run_full;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [LINK_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr;

    function automatic logic [AW-1:0] in_cluster_idx(input logic [CLU_W-1:0] c);
        logic [CX_W-1:0] cx;
        cx = CX_W'(c);
        return cx[AW-1:0];
    endfunction

    // working table size
    assign cfg_x = LX_W'(cfg_reg);
    assign lim   = (cfg_x > LX_W'(ENTRIES)) ? LIM_W'(ENTRIES) : cfg_x[LIM_W-1:0];

    // index views of narrow and wide values
    assign clu_x   = CX_W'(clu_reg);
    assign clu_idx = clu_x[AW-1:0];
    assign cur_x   = CX_W'(cur_reg);
    assign k_x     = KX_W'(k_reg);
    assign k_idx   = k_reg[AW-1:0];

    // link checks on the entry just read
    assign link_ok  = (rd_data != FREE_VAL) && (rd_data < END_LIMIT);
    assign link_in  = rd_data < LINK_W'(lim);
    assign run_full = cnt_reg == CNT_W'(MAX_RUN - 1);

    // status to controller
    always_comb begin
        stat.op         = op_reg;
        stat.in_range   = LINK_W'(clu_reg) < LINK_W'(lim);
        stat.link_prev  = linkp_reg;
        stat.k_out      = k_reg >= lim;
        stat.k_next_out = ((LIM_W+1)'(k_reg) + (LIM_W+1)'(1)) >= (LIM_W+1)'(lim);
        stat.rd_zero    = rd_data == FREE_VAL;
        stat.free_done  = !link_ok || !link_in;
        stat.pend_last  = plast_reg;
        stat.out_free   = !mvalid_reg || m_axis_tready;
    end

    // table write and read ports
    always_comb begin
        ram_we    = cmd.wr_en;
        ram_waddr = cur_reg;
        ram_wdata = FREE_VAL;
        case (cmd.wr_kind)
            WK_VAL: begin
                ram_waddr = clu_idx;
                ram_wdata = val_reg;
            end
            WK_ZERO: begin
                ram_waddr = cur_reg;
                ram_wdata = FREE_VAL;
            end
            WK_END: begin
                ram_waddr = k_idx;
                ram_wdata = END_MARK;
            end
            WK_LINK: begin
                ram_waddr = clu_idx;
                ram_wdata = LINK_W'(k_reg);
            end
            default: begin
                ram_waddr = cur_reg;
                ram_wdata = FREE_VAL;
            end
        endcase
        ram_raddr = cmd.rd_k ? k_idx : cur_reg;
    end

    fcc_ram #(
        .WIDTH (LINK_W),
        .DEPTH (ENTRIES)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.rd_en),
        .raddr (ram_raddr),
        .rdata (rd_data)
    );

    // item registers, walk pointer, counters
    always_comb begin
        cfg_next   = cfg_we ? cfg_wdata : cfg_reg;
        op_next    = op_reg;
        clu_next   = clu_reg;
        val_next   = val_reg;
        linkp_next = linkp_reg;
        cur_next   = cur_reg;
        cnt_next   = cnt_reg;
        k_next     = k_reg;
        if (cmd.load) begin
            op_next    = in_opcode;
            clu_next   = in_cluster;
            val_next   = in_link_value;
            linkp_next = in_link_prev;
            cur_next   = (32'(in_cluster) >= ENTRIES) ? '0
                         : in_cluster_idx(in_cluster);
            cnt_next   = '0;
            k_next     = LIM_W'(2);
        end
        if (cmd.adv_cur) begin
            cur_next = rd_data[AW-1:0];
            cnt_next = cnt_reg + CNT_W'(1);
        end
        if (cmd.adv_k) begin
            k_next = k_reg + LIM_W'(1);
        end
    end

    // pending result
    always_comb begin
        pclu_next  = pclu_reg;
        pval_next  = pval_reg;
        pst_next   = pst_reg;
        plast_next = plast_reg;
        if (cmd.set_res) begin
            pclu_next  = clu_reg;
            pval_next  = FREE_VAL;
            pst_next   = ST_OK;
            plast_next = 1'b1;
            case (cmd.res_kind)
                R_ERR: begin
                    pst_next = ST_RANGE;
                end
                R_ALLOC_ERR: begin
                    pclu_next = '0;
                    pst_next  = ST_RANGE;
                end
                R_FULL: begin
                    pclu_next = '0;
                    pst_next  = ST_FULL;
                end
                R_ALLOC_OK: begin
                    pclu_next = k_x[CLU_W-1:0];
                end
                R_WRITE: begin
                    pval_next = val_reg;
                end
                R_READ: begin
                    pval_next = rd_data;
                end
                R_TRACE: begin
                    pclu_next = cur_x[CLU_W-1:0];
                    if (!link_ok) begin
                        pst_next = ST_OK;
                    end else if (!link_in) begin
                        pval_next = rd_data;
                        pst_next  = ST_RANGE;
                    end else if (run_full) begin
                        pval_next = rd_data;
                        pst_next  = ST_TRUNC;
                    end else begin
                        plast_next = 1'b0;
                    end
                end
                R_FREE: begin
                    pval_next = LINK_W'(cnt_reg) + LINK_W'(1);
                    pst_next  = (link_ok && !link_in) ? ST_RANGE : ST_OK;
                end
                default: begin
                    pst_next = ST_RANGE;
                end
            endcase
        end
    end

    // output register
    always_comb begin
        mvalid_next = mvalid_reg;
        mclu_next   = mclu_reg;
        mval_next   = mval_reg;
        mst_next    = mst_reg;
        mlast_next  = mlast_reg;
        if (cmd.emit) begin
            mvalid_next = 1'b1;
            mclu_next   = pclu_reg;
            mval_next   = pval_reg;
            mst_next    = pst_reg;
            mlast_next  = plast_reg;
        end else if (m_axis_tready) begin
            mvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg    <= CFG_RESET;
            mvalid_reg <= 1'b0;
        end else begin
            cfg_reg    <= cfg_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg    <= op_next;
        clu_reg   <= clu_next;
        val_reg   <= val_next;
        linkp_reg <= linkp_next;
        cur_reg   <= cur_next;
        cnt_reg   <= cnt_next;
        k_reg     <= k_next;
        pclu_reg  <= pclu_next;
        pval_reg  <= pval_next;
        pst_reg   <= pst_next;
        plast_reg <= plast_next;
        mclu_reg  <= mclu_next;
        mval_reg  <= mval_next;
        mst_reg   <= mst_next;
        mlast_reg <= mlast_next;
    end

    assign m_axis_tvalid = mvalid_reg;
    assign m_axis_tdata  = {mst_reg, mval_reg, mclu_reg};
    assign m_axis_tlast  = mlast_reg;

endmodule

FILE: design/fcc_ctrl.sv
module fcc_ctrl import fcc_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DECODE = 6'b000010,
        S_RD     = 6'b000100,
        S_EVAL   = 6'b001000,
        S_LINK   = 6'b010000,
        S_EMIT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = state_reg == S_IDLE;

    // sequencing of table accesses and results
    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.wr_kind  = WK_VAL;
        cmd.res_kind = R_ERR;
        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                case (stat.op)
                    OP_WRITE: begin
                        cmd.set_res = 1'b1;
                        if (stat.in_range) begin
                            cmd.wr_en    = 1'b1;
                            cmd.wr_kind  = WK_VAL;
                            cmd.res_kind = R_WRITE;
                        end else begin
                            cmd.res_kind = R_ERR;
                        end
                        state_next = S_EMIT;
                    end
                    OP_READ, OP_TRACE, OP_FREE: begin
                        if (stat.in_range) begin
                            state_next = S_RD;
                        end else begin
                            cmd.set_res  = 1'b1;
                            cmd.res_kind = R_ERR;
                            state_next   = S_EMIT;
                        end
                    end
                    OP_ALLOC: begin
                        if (stat.link_prev && !stat.in_range) begin
                            cmd.set_res  = 1'b1;
                            cmd.res_kind = R_ALLOC_ERR;
                            state_next   = S_EMIT;
                        end else if (stat.k_out) begin
                            cmd.set_res  = 1'b1;
                            cmd.res_kind = R_FULL;
                            state_next   = S_EMIT;
                        end else begin
                            state_next = S_RD;
                        end
                    end
                    default: begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_RD: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_k   = stat.op == OP_ALLOC;
                state_next = S_EVAL;
            end
            S_EVAL: begin
                case (stat.op)
                    OP_READ: begin
                        cmd.set_res  = 1'b1;
                        cmd.res_kind = R_READ;
                        state_next   = S_EMIT;
                    end
                    OP_TRACE: begin
                        cmd.set_res  = 1'b1;
                        cmd.res_kind = R_TRACE;
                        cmd.adv_cur  = 1'b1;
                        state_next   = S_EMIT;
                    end
                    OP_FREE: begin
                        cmd.wr_en   = 1'b1;
                        cmd.wr_kind = WK_ZERO;
                        cmd.adv_cur = 1'b1;
                        if (stat.free_done) begin
                            cmd.set_res  = 1'b1;
                            cmd.res_kind = R_FREE;
                            state_next   = S_EMIT;
                        end else begin
                            state_next = S_RD;
                        end
                    end
                    OP_ALLOC: begin
                        if (stat.rd_zero) begin
                            cmd.wr_en   = 1'b1;
                            cmd.wr_kind = WK_END;
                            if (stat.link_prev) begin
                                state_next = S_LINK;
                            end else begin
                                cmd.set_res  = 1'b1;
                                cmd.res_kind = R_ALLOC_OK;
                                state_next   = S_EMIT;
                            end
                        end else begin
                            cmd.adv_k = 1'b1;
                            if (stat.k_next_out) begin
                                cmd.set_res  = 1'b1;
                                cmd.res_kind = R_FULL;
                                state_next   = S_EMIT;
                            end else begin
                                state_next = S_RD;
                            end
                        end
                    end
                    default: begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_LINK: begin
                cmd.wr_en    = 1'b1;
                cmd.wr_kind  = WK_LINK;
                cmd.set_res  = 1'b1;
                cmd.res_kind = R_ALLOC_OK;
                state_next   = S_EMIT;
            end
            S_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = stat.pend_last ? S_IDLE : S_RD;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: design/fat_cluster_chain_engine.sv
// channel   dir  signals                    contents
// s_axis    in   tvalid tready tdata tuser  one operation
// m_axis    out  tvalid tready tdata tlast  result transfers, tlast on the final one
// cfg       in   cfg_we cfg_wdata           entries_in_use
//
// every operation passes a decode step and an emit step. read, trace and free add
// a read step and an evaluate step per table entry; allocate adds them per scanned
// entry, plus a link step when chaining. the table has one write port and one
// registered read port. reset clears the controller, the output valid flag and
// entries_in_use only; the table holds no defined contents until written. a
// stalled output holds the walk in its emit step; the next operation is taken
// as soon as the final result sits in the output register.
module fat_cluster_chain_engine import fcc_pkg::*; #(
    parameter int ENTRIES = 1024,
    parameter int MAX_RUN = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [CFG_W-1:0]              cfg_wdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // cluster[9:0], link_value[37:10], link_prev[38], zero[39]
    input  logic [39:0]                   s_axis_tdata,
    // opcode[2:0]
    input  logic [OP_W-1:0]               s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // result_cluster[9:0], result_value[37:10], status[39:38]
    output logic [CLU_W+LINK_W+STAT_W-1:0] m_axis_tdata,
    output logic                          m_axis_tlast
);

    cmd_t  cmd;
    stat_t stat;

    // operation sequencer
    fcc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // table, walk registers and output register
    fcc_datapath #(
        .ENTRIES (ENTRIES),
        .MAX_RUN (MAX_RUN)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_opcode      (s_axis_tuser),
        .in_cluster     (s_axis_tdata[CLU_W-1:0]),
        .in_link_value  (s_axis_tdata[CLU_W+LINK_W-1:CLU_W]),
        .in_link_prev   (s_axis_tdata[CLU_W+LINK_W]),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tlast   (m_axis_tlast)
    );

endmodule

FILE: bench/fat_cluster_chain_engine_checker.sv
`timescale 1ns / 100ps

module fat_cluster_chain_engine_checker import fcc_pkg::*; (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [CFG_W-1:0]                cfg_wdata,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    // cluster[9:0], link_value[37:10], link_prev[38], zero[39]
    input  logic [39:0]                     s_tdata,
    // opcode[2:0]
    input  logic [OP_W-1:0]                 s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    // result_cluster[9:0], result_value[37:10], status[39:38]
    input  logic [CLU_W+LINK_W+STAT_W-1:0]  m_tdata,
    input  logic                            m_tlast,
    output int unsigned                     pending,
    output int unsigned                     fail_count
);

    localparam int TABLE_DEPTH = 1024;
    localparam int RUN_LIMIT   = 64;

    typedef struct packed {
        logic [CLU_W-1:0]  clu;
        logic [LINK_W-1:0] value;
        logic [STAT_W-1:0] status;
        logic              last;
    } chain_result_t;

    // shadow of the allocation table and of entries_in_use
    logic [LINK_W-1:0] fat_entries [0:TABLE_DEPTH-1];
    logic [CFG_W-1:0]  entry_count;
    chain_result_t     chain_results_due [$];
    int unsigned       mismatch_cnt;

    initial begin
        pending      = 0;
        fail_count   = 0;
        mismatch_cnt = 0;
        entry_count  = CFG_RESET;
        for (int i = 0; i < TABLE_DEPTH; i++)
            fat_entries[i] = FREE_VAL;
    end

    // entries actually covered by the table
    function automatic int unsigned table_span();
        return (entry_count > TABLE_DEPTH) ? TABLE_DEPTH : entry_count;
    endfunction

    function automatic bit follows_on(input logic [LINK_W-1:0] v);
        return (v != FREE_VAL) && (v < END_LIMIT);
    endfunction

    function automatic void queue_result(input logic [CLU_W-1:0] clu,
                                         input logic [LINK_W-1:0] value,
                                         input logic [STAT_W-1:0] status,
                                         input logic last);
        chain_result_t r;
        r.clu    = clu;
        r.value  = value;
        r.status = status;
        r.last   = last;
        chain_results_due.push_back(r);
    endfunction

    // carry out one operation on the shadow table and queue its results
    function automatic void apply_table_op(input logic [OP_W-1:0] op,
                                           input logic [CLU_W-1:0] clu,
                                           input logic [LINK_W-1:0] value,
                                           input logic link_prev);
        int unsigned       lim;
        int unsigned       run_len;
        int unsigned       freed;
        int unsigned       guard;
        int unsigned       k;
        logic [CLU_W-1:0]  cur;
        logic [LINK_W-1:0] nxt;
        logic [STAT_W-1:0] st;
        bit                done;

        lim = table_span();
        case (op)
            OP_WRITE: begin
                if (clu >= lim) begin
                    queue_result(clu, FREE_VAL, ST_RANGE, 1'b1);
                end else begin
                    fat_entries[clu] = value;
                    queue_result(clu, value, ST_OK, 1'b1);
                end
            end
            OP_READ: begin
                if (clu >= lim)
                    queue_result(clu, FREE_VAL, ST_RANGE, 1'b1);
                else
                    queue_result(clu, fat_entries[clu], ST_OK, 1'b1);
            end
            OP_TRACE: begin
                if (clu >= lim) begin
                    queue_result(clu, FREE_VAL, ST_RANGE, 1'b1);
                end else begin
                    // one result per cluster until the chain ends or the run is cut
                    cur     = clu;
                    run_len = 0;
                    done    = 1'b0;
                    while (!done) begin
                        nxt = fat_entries[cur];
                        run_len++;
                        if (!follows_on(nxt)) begin
                            queue_result(cur, FREE_VAL, ST_OK, 1'b1);
                            done = 1'b1;
                        end else if (nxt >= lim) begin
                            queue_result(cur, nxt, ST_RANGE, 1'b1);
                            done = 1'b1;
                        end else if (run_len >= RUN_LIMIT) begin
                            queue_result(cur, nxt, ST_TRUNC, 1'b1);
                            done = 1'b1;
                        end else begin
                            queue_result(cur, FREE_VAL, ST_OK, 1'b0);
                            cur = nxt[CLU_W-1:0];
                        end
                    end
                end
            end
            OP_FREE: begin
                if (clu >= lim) begin
                    queue_result(clu, FREE_VAL, ST_RANGE, 1'b1);
                end else begin
                    cur   = clu;
                    freed = 0;
                    st    = ST_OK;
                    done  = 1'b0;
                    for (guard = 0; guard <= TABLE_DEPTH && !done; guard++) begin
                        nxt = fat_entries[cur];
                        fat_entries[cur] = FREE_VAL;
                        freed++;
                        if (!follows_on(nxt)) begin
                            done = 1'b1;
                        end else if (nxt >= lim) begin
                            st   = ST_RANGE;
                            done = 1'b1;
                        end else begin
                            cur = nxt[CLU_W-1:0];
                        end
                    end
                    queue_result(clu, freed[LINK_W-1:0], st, 1'b1);
                end
            end
            OP_ALLOC: begin
                if (link_prev && clu >= lim) begin
                    queue_result('0, FREE_VAL, ST_RANGE, 1'b1);
                end else begin
                    // lowest free entry from index 2 up
                    k = 2;
                    while (k < lim && fat_entries[k] != FREE_VAL)
                        k++;
                    if (k >= lim) begin
                        queue_result('0, FREE_VAL, ST_FULL, 1'b1);
                    end else begin
                        fat_entries[k] = END_MARK;
                        if (link_prev)
                            fat_entries[clu] = k[LINK_W-1:0];
                        queue_result(k[CLU_W-1:0], FREE_VAL, ST_OK, 1'b1);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_cnt++;
        end
    endfunction

    // watch config writes, input transfers and result transfers
    always @(posedge aclk) begin : watch
        chain_result_t got;
        chain_result_t want;
        if (!aresetn) begin
            entry_count = CFG_RESET;
            chain_results_due.delete();
        end else begin
            if (cfg_we)
                entry_count = cfg_wdata;
            if (s_tvalid && s_tready)
                apply_table_op(s_tuser, s_tdata[CLU_W-1:0],
                               s_tdata[CLU_W+LINK_W-1:CLU_W], s_tdata[CLU_W+LINK_W]);
            if (m_tvalid && m_tready) begin
                got.clu    = m_tdata[CLU_W-1:0];
                got.value  = m_tdata[CLU_W+LINK_W-1:CLU_W];
                got.status = m_tdata[CLU_W+LINK_W+STAT_W-1:CLU_W+LINK_W];
                got.last   = m_tlast;
                if (chain_results_due.size() == 0) begin
                    $error("result transfer with nothing expected: cluster %0d value %0d",
                           got.clu, got.value);
                    mismatch_cnt++;
                end else begin
                    want = chain_results_due.pop_front();
                    check_field("result_cluster", 32'(want.clu), 32'(got.clu));
                    check_field("result_value", 32'(want.value), 32'(got.value));
                    check_field("status", 32'(want.status), 32'(got.status));
                    check_field("last", 32'(want.last), 32'(got.last));
                end
            end
        end
        pending    <= chain_results_due.size();
        fail_count <= mismatch_cnt;
    end

endmodule

FILE: bench/fat_cluster_chain_engine_tb.sv
`timescale 1ns / 100ps

module fat_cluster_chain_engine_tb;
    import fcc_pkg::*;

    localparam int unsigned CYCLE_LIMIT      = 2_000_000;
    localparam int unsigned SETTLE_CYCLES    = 64;
    localparam int unsigned ITEMS_PER_PHASE  = 32;
    localparam int unsigned FULL_TABLE       = 1024;
    localparam int unsigned SMALLEST_TABLE   = 3;
    // entries cleared at the start; random phases keep their tables inside this span
    localparam int unsigned CLEAR_SPAN       = 80;

    // opcodes the block does not decode
    localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

    logic                           aclk = 1'b0;
    logic                           aresetn;
    logic                           cfg_we;
    logic [CFG_W-1:0]               cfg_wdata;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [39:0]                    s_axis_tdata;
    logic [OP_W-1:0]                s_axis_tuser;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [CLU_W+LINK_W+STAT_W-1:0] m_axis_tdata;
    logic                           m_axis_tlast;

    int unsigned      idle_pct    = 0;
    int unsigned      stall_pct   = 0;
    int unsigned      cycle_count = 0;
    int unsigned      table_size  = CFG_RESET;
    int unsigned      pending;
    int unsigned      fail_count;
    logic [CLU_W-1:0] last_out_cluster = '0;

    fat_cluster_chain_engine dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    fat_cluster_chain_engine_checker watcher (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_axis_tvalid),
        .s_tready   (s_axis_tready),
        .s_tdata    (s_axis_tdata),
        .s_tuser    (s_axis_tuser),
        .m_tvalid   (m_axis_tvalid),
        .m_tready   (m_axis_tready),
        .m_tdata    (m_axis_tdata),
        .m_tlast    (m_axis_tlast),
        .pending    (pending),
        .fail_count (fail_count)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // receiver back-pressure
    always @(posedge aclk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // last cluster handed out, used to chain allocations
    always @(posedge aclk) begin
        if (m_axis_tvalid && m_axis_tready)
            last_out_cluster <= m_axis_tdata[CLU_W-1:0];
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // one operation, with a random gap first, held until the transfer
    task automatic send_op(input logic [OP_W-1:0] op, input logic [CLU_W-1:0] clu,
                           input logic [LINK_W-1:0] value, input logic link_prev);
        if ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {1'b0, link_prev, value, clu};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
    endtask

    // wait until every expected result has come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic set_table_size(input int unsigned size);
        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= size[CFG_W-1:0];
        @(posedge aclk);
        cfg_we     <= 1'b0;
        table_size = size;
    endtask

    function automatic logic [CLU_W-1:0] rand_cluster();
        return CLU_W'($urandom_range(table_size - 1));
    endfunction

    function automatic logic [CLU_W-1:0] rand_any_cluster();
        return CLU_W'($urandom());
    endfunction

    function automatic logic [LINK_W-1:0] rand_value();
        return LINK_W'($urandom());
    endfunction

    function automatic logic rand_bit();
        return 1'($urandom_range(1));
    endfunction

    // mostly well-formed chains and allocation runs, some noise
    task automatic run_random(input int unsigned target);
        int unsigned       sent;
        int unsigned       len;
        int unsigned       i;
        int unsigned       files;
        logic [CLU_W-1:0]  path [$];
        logic [CLU_W-1:0]  head;
        logic [LINK_W-1:0] tail_val;
        logic [LINK_W-1:0] value;

        sent = 0;
        while (sent < target) begin
            if ($urandom_range(99) < 55) begin
                // chain written link by link, walked, then read and freed, freed, or walked from its tail
                path.delete();
                if ($urandom_range(11) == 0 && table_size > 70)
                    len = $urandom_range(60, 68);
                else
                    len = $urandom_range(1, 6);
                for (i = 0; i < len; i++)
                    path.push_back(rand_cluster());
                case ($urandom_range(4))
                    0: tail_val = END_MARK;
                    1: tail_val = LINK_W'($urandom_range(END_LIMIT, END_MARK));
                    2: tail_val = FREE_VAL;
                    3: begin
                        if ($urandom_range(1))
                            tail_val = LINK_W'(table_size + $urandom_range(7));
                        else
                            tail_val = LINK_W'($urandom_range(table_size, END_LIMIT - 1));
                    end
                    default: tail_val = LINK_W'(path[$urandom_range(len - 1)]);
                endcase
                for (i = 0; i < len; i++) begin
                    if (i + 1 < len)
                        value = LINK_W'(path[i + 1]);
                    else
                        value = tail_val;
                    send_op(OP_WRITE, path[i], value, rand_bit());
                end
                send_op(OP_TRACE, path[0], rand_value(), rand_bit());
                sent += len + 1;
                case ($urandom_range(2))
                    0: begin
                        send_op(OP_READ, path[$urandom_range(len - 1)], rand_value(),
                                rand_bit());
                        send_op(OP_FREE, path[0], rand_value(), rand_bit());
                        send_op(OP_TRACE, path[0], rand_value(), rand_bit());
                        sent += 3;
                    end
                    1: begin
                        send_op(OP_FREE, path[0], rand_value(), rand_bit());
                        sent += 1;
                    end
                    default: begin
                        send_op(OP_TRACE, path[len - 1], rand_value(), rand_bit());
                        sent += 1;
                    end
                endcase
            end else if ($urandom_range(99) < 45) begin
                // file grown one allocation at a time, each linked to the last
                files = $urandom_range(1, 5);
                send_op(OP_ALLOC, rand_any_cluster(), rand_value(), 1'b0);
                drain();
                head = last_out_cluster;
                for (i = 1; i < files; i++) begin
                    send_op(OP_ALLOC, last_out_cluster, rand_value(), 1'b1);
                    drain();
                end
                send_op(OP_TRACE, head, rand_value(), rand_bit());
                sent += files + 1;
                if ($urandom_range(1)) begin
                    send_op(OP_FREE, head, rand_value(), rand_bit());
                    sent += 1;
                end
            end else begin
                // single operation with arbitrary fields
                value = rand_value();
                case ($urandom_range(2))
                    0: value = LINK_W'($urandom_range(table_size + 3));
                    1: value = LINK_W'(END_LIMIT + $urandom_range(7));
                    default: ;
                endcase
                if ($urandom_range(19) == 0) begin
                    send_op(OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI)),
                            rand_any_cluster(), value, rand_bit());
                end else begin
                    send_op(OP_W'($urandom_range(OP_WRITE, OP_ALLOC)),
                            rand_any_cluster(), value, rand_bit());
                    sent += 1;
                end
            end
        end
    endtask

    initial begin
        int unsigned i;

        aresetn       <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_wdata     <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_WRITE;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // full table, low entries cleared before anything reads them
        set_table_size(CFG_RESET);
        for (i = 0; i < CLEAR_SPAN; i++)
            send_op(OP_WRITE, CLU_W'(i), FREE_VAL, 1'b0);

        // directed: chains, extremes, loops, range links, allocation
        idle_pct  = 31;
        stall_pct = 31;
        send_op(OP_WRITE, 5, 6, 1'b0);
        send_op(OP_WRITE, 6, 7, 1'b0);
        send_op(OP_WRITE, 7, END_MARK, 1'b0);
        send_op(OP_TRACE, 5, FREE_VAL, 1'b0);
        send_op(OP_READ, 6, FREE_VAL, 1'b0);
        send_op(OP_WRITE, CLU_W'(FULL_TABLE - 1), '1, 1'b1);
        send_op(OP_READ, CLU_W'(FULL_TABLE - 1), FREE_VAL, 1'b0);
        send_op(OP_WRITE, 10, 10, 1'b0);
        send_op(OP_TRACE, 10, FREE_VAL, 1'b0);
        send_op(OP_WRITE, 20, END_LIMIT - LINK_W'(1), 1'b0);
        send_op(OP_TRACE, 20, FREE_VAL, 1'b0);
        send_op(OP_WRITE, 21, END_LIMIT, 1'b0);
        send_op(OP_TRACE, 21, FREE_VAL, 1'b0);
        send_op(OP_FREE, 5, FREE_VAL, 1'b0);
        send_op(OP_FREE, 20, FREE_VAL, 1'b0);
        send_op(OP_ALLOC, 0, FREE_VAL, 1'b0);
        send_op(OP_ALLOC, 2, FREE_VAL, 1'b1);
        // lowest free entry is now 4, so this links it to itself
        send_op(OP_ALLOC, 4, FREE_VAL, 1'b1);
        send_op(OP_TRACE, 4, FREE_VAL, 1'b0);
        send_op(OP_UNUSED_LO, '1, '1, 1'b1);
        send_op(OP_UNUSED_HI, '1, '1, 1'b1);

        // smallest table: range errors and a full table
        set_table_size(SMALLEST_TABLE);
        send_op(OP_WRITE, 3, END_MARK, 1'b0);
        send_op(OP_READ, CLU_W'(FULL_TABLE - 1), FREE_VAL, 1'b0);
        send_op(OP_TRACE, 2, FREE_VAL, 1'b0);
        send_op(OP_TRACE, 900, FREE_VAL, 1'b0);
        send_op(OP_FREE, 3, FREE_VAL, 1'b0);
        send_op(OP_ALLOC, 3, FREE_VAL, 1'b1);
        send_op(OP_ALLOC, 1, FREE_VAL, 1'b0);

        // random phases, one idling pattern and table size each
        set_table_size(CLEAR_SPAN);
        idle_pct  = 0;
        stall_pct = 0;
        run_random(ITEMS_PER_PHASE);

        set_table_size(CLEAR_SPAN - 1);
        idle_pct  = 52;
        stall_pct = 0;
        run_random(ITEMS_PER_PHASE);

        set_table_size($urandom_range(SMALLEST_TABLE, 48));
        idle_pct  = 0;
        stall_pct = 52;
        run_random(ITEMS_PER_PHASE);

        set_table_size($urandom_range(SMALLEST_TABLE, CLEAR_SPAN));
        idle_pct  = 31;
        stall_pct = 31;
        run_random(ITEMS_PER_PHASE);

        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
